// ----- hw/rtl/stf_pkg.sv -----
`default_nettype none
package stf_pkg;

   localparam int RIM_VERTICES  = 6;
   localparam int INDEX_BITS    = 24;
   localparam int VNUM_BITS     = 27;
   localparam int SLOTS         = 2 * RIM_VERTICES + 1;
   localparam int SLOT_BITS     = $clog2(SLOTS);
   localparam int SQRT_STEPS    = 32;
   localparam int DIV_STEPS     = 15;
   localparam int REQ_BITS      = 224;
   localparam int RSP_BITS      = 240;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;

   localparam logic        COLOR_MODE_RESET   = 1'b0;
   localparam logic [15:0] RADIUS_SCALE_RESET = 16'd6144;
   localparam logic [14:0] TAN_THRESH_RESET   = 15'd14746;
   localparam logic [15:0] MIN_RADIUS_RESET   = 16'd1;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_COLOR_MODE,
      CSR_RADIUS_SCALE,
      CSR_TAN_THRESHOLD,
      CSR_MIN_RADIUS
   } csr_index_type;

   typedef struct packed {
      logic        color_mode;
      logic [15:0] radius_scale;
      logic [14:0] tan_threshold;
      logic [15:0] min_radius;
   } cfg_type;

   // one surfel as it travels down the axis pipeline
   typedef struct packed {
      logic [INDEX_BITS-1:0] idx;
      logic [2:0][31:0]      pos;
      logic [2:0][15:0]      nrm;
      logic [31:0]           radius;
      logic [2:0][7:0]       rgb;
      logic                  sel;
      logic [2:0][31:0]      dn;
      logic [47:0]           rsprod;
      logic [31:0]           color;
      logic [VNUM_BITS-1:0]  base;
      logic [2:0]            aneg;
      logic [2:0][30:0]      amag;
      logic [36:0]           rs;
      logic                  bad;
      logic [2:0][61:0]      sq;
      logic [63:0]           rem;
      logic [63:0]           res;
      logic [31:0]           len;
      logic [2:0][46:0]      drem;
      logic [2:0][14:0]      quot;
      logic [2:0][15:0]      tan;
      logic [5:0][31:0]      nt;
      logic [2:0][17:0]      bax;
   } work_type;

   // q28 (pi/2)^k/k! for k = 1, 3, 5, 7, 9
   localparam longint unsigned SIN_COEF [5] = '{
      64'd421657428, 64'd173399667, 64'd21392327, 64'd1256749, 64'd43068
   };

   // shift right by 14, rounding half away from zero
   function automatic longint rshr14(longint v);
      longint unsigned m;
      m = (v < 0) ? (64'd0 - 64'(v)) : 64'(v);
      m = (m + 64'd8192) >> 14;
      return (v < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint unsigned quarter_sin(longint unsigned u);
      longint unsigned z;
      longint unsigned acc;
      z = u * u;
      acc = SIN_COEF[4];
      for (int k = 3; k >= 0; k--) acc = SIN_COEF[k] - ((acc * z) >> 28);
      acc = (acc * u + (64'd1 << 27)) >> 28;
      if (acc > 64'd16384) acc = 64'd16384;
      return acc;
   endfunction

   // q1.14 cosine or sine of rim angle j, evaluated at elaboration
   function automatic longint trig_val(int j, bit want_cos);
      longint unsigned p;
      longint unsigned u;
      longint          a;
      longint          b;
      longint          c;
      longint          s;
      p = ((64'(j) * 64'd65536 + 64'(RIM_VERTICES / 2)) / 64'(RIM_VERTICES)) & 64'hFFFF;
      u = p & 64'h3FFF;
      a = longint'(quarter_sin(u));
      b = longint'(quarter_sin(64'd16384 - u));
      case (p >> 14)
         64'd0: begin s = a;  c = b;  end
         64'd1: begin s = b;  c = -a; end
         64'd2: begin s = -a; c = -b; end
         default: begin s = -b; c = a; end
      endcase
      return want_cos ? c : s;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/stf_axis.sv -----
`default_nettype none
module stf_axis (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                in_valid,
   output logic                               in_ready,
   input  wire  [stf_pkg::REQ_BITS-1:0]       in_data,
   input  stf_pkg::cfg_type                   cfg,
   output logic                               out_valid,
   input  wire                                out_take,
   output stf_pkg::work_type                  out_item
);

   localparam int S_PROD  = 1;
   localparam int S_AXIS  = 2;
   localparam int S_SQ    = 3;
   localparam int S_SUM   = 4;
   localparam int S_ROOT  = 5;
   localparam int S_LEN   = S_ROOT + stf_pkg::SQRT_STEPS;
   localparam int S_DIV   = S_LEN + 1;
   localparam int S_TAN   = S_DIV + stf_pkg::DIV_STEPS;
   localparam int S_NT    = S_TAN + 1;
   localparam int S_BAX   = S_NT + 1;
   localparam int NSTAGES = S_BAX + 1;

   stf_pkg::work_type st_ff [NSTAGES];
   stf_pkg::work_type st_in [NSTAGES];
   logic [NSTAGES-1:0] vld_ff;
   logic               fen;

   // whole pipeline moves when the tail is empty or handed off
   assign fen       = !vld_ff[NSTAGES-1] || out_take;
   assign in_ready  = fen;
   assign out_valid = vld_ff[NSTAGES-1];
   assign out_item  = st_ff[NSTAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (fen) begin
         vld_ff <= {vld_ff[NSTAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (fen) begin
         for (int k = 0; k < NSTAGES; k++) st_ff[k] <= st_in[k];
      end
   end

   always_comb begin
      st_in[0]        = '0;
      st_in[0].idx    = in_data[23:0];
      st_in[0].pos[0] = in_data[55:24];
      st_in[0].pos[1] = in_data[87:56];
      st_in[0].pos[2] = in_data[119:88];
      st_in[0].nrm[0] = in_data[135:120];
      st_in[0].nrm[1] = in_data[151:136];
      st_in[0].nrm[2] = in_data[167:152];
      st_in[0].radius = in_data[199:168];
      st_in[0].rgb[0] = in_data[207:200];
      st_in[0].rgb[1] = in_data[215:208];
      st_in[0].rgb[2] = in_data[223:216];
   end

   // seed selection, d*n products, radius product, colour, base index
   always_comb begin
      logic [15:0] n0;
      logic [16:0] absn0;
      logic [15:0] dsel;
      st_in[S_PROD] = st_ff[S_PROD-1];
      n0    = st_ff[S_PROD-1].nrm[0];
      absn0 = n0[15] ? (17'd0 - {1'b1, n0}) : {1'b0, n0};
      st_in[S_PROD].sel = absn0 > {2'b0, cfg.tan_threshold};
      dsel = st_in[S_PROD].sel ? st_ff[S_PROD-1].nrm[1] : n0;
      for (int i = 0; i < 3; i++) begin
         st_in[S_PROD].dn[i] = $signed(dsel) * $signed(st_ff[S_PROD-1].nrm[i]);
      end
      st_in[S_PROD].rsprod = st_ff[S_PROD-1].radius * cfg.radius_scale;
      if (cfg.color_mode) begin
         st_in[S_PROD].color = 32'(st_ff[S_PROD-1].idx) + 32'd1;
      end else begin
         st_in[S_PROD].color = {8'hFF, st_ff[S_PROD-1].rgb[2], st_ff[S_PROD-1].rgb[1],
                                st_ff[S_PROD-1].rgb[0]};
      end
      st_in[S_PROD].base = stf_pkg::VNUM_BITS'(
         stf_pkg::VNUM_BITS'(st_ff[S_PROD-1].idx) *
         stf_pkg::VNUM_BITS'(stf_pkg::RIM_VERTICES + 1));
   end

   // gram-schmidt vector, scaled radius
   always_comb begin
      logic signed [32:0] av;
      logic [32:0]        am;
      logic               e;
      logic [48:0]        rr;
      st_in[S_AXIS] = st_ff[S_AXIS-1];
      for (int i = 0; i < 3; i++) begin
         e  = (i == 1) ? st_ff[S_AXIS-1].sel : ((i == 0) ? !st_ff[S_AXIS-1].sel : 1'b0);
         av = $signed({4'b0, e, 28'b0}) -
              $signed({st_ff[S_AXIS-1].dn[i][31], st_ff[S_AXIS-1].dn[i]});
         am = av[32] ? (33'd0 - av) : av;
         st_in[S_AXIS].aneg[i] = av[32];
         st_in[S_AXIS].amag[i] = am[30:0];
      end
      rr = {1'b0, st_ff[S_AXIS-1].rsprod} + 49'd2048;
      st_in[S_AXIS].rs  = rr[48:12];
      st_in[S_AXIS].bad = rr[48:12] <= {21'b0, cfg.min_radius};
   end

   always_comb begin
      st_in[S_SQ] = st_ff[S_SQ-1];
      for (int i = 0; i < 3; i++) begin
         st_in[S_SQ].sq[i] = st_ff[S_SQ-1].amag[i] * st_ff[S_SQ-1].amag[i];
      end
   end

   always_comb begin
      st_in[S_SUM]     = st_ff[S_SUM-1];
      st_in[S_SUM].rem = {2'b0, st_ff[S_SUM-1].sq[0]} + {2'b0, st_ff[S_SUM-1].sq[1]} +
                         {2'b0, st_ff[S_SUM-1].sq[2]};
      st_in[S_SUM].res = '0;
   end

   // integer square root, one result bit per stage
   for (genvar k = 0; k < stf_pkg::SQRT_STEPS; k++) begin : g_root
      localparam logic [63:0] RBIT = 64'd1 << (62 - 2 * k);
      always_comb begin
         logic [63:0] trial;
         st_in[S_ROOT+k] = st_ff[S_ROOT+k-1];
         trial = st_ff[S_ROOT+k-1].res + RBIT;
         if (st_ff[S_ROOT+k-1].rem >= trial) begin
            st_in[S_ROOT+k].rem = st_ff[S_ROOT+k-1].rem - trial;
            st_in[S_ROOT+k].res = (st_ff[S_ROOT+k-1].res >> 1) + RBIT;
         end else begin
            st_in[S_ROOT+k].res = st_ff[S_ROOT+k-1].res >> 1;
         end
      end
   end

   always_comb begin
      st_in[S_LEN]     = st_ff[S_LEN-1];
      st_in[S_LEN].len = st_ff[S_LEN-1].res[31:0];
      for (int i = 0; i < 3; i++) begin
         st_in[S_LEN].drem[i] = {2'b0, st_ff[S_LEN-1].amag[i], 14'b0} +
                                {16'b0, st_ff[S_LEN-1].res[31:1]};
      end
      st_in[S_LEN].quot = '0;
   end

   // restoring divide by the length, one quotient bit per stage, three lanes
   for (genvar k = 0; k < stf_pkg::DIV_STEPS; k++) begin : g_div
      localparam int SH = stf_pkg::DIV_STEPS - 1 - k;
      always_comb begin
         logic [46:0] dv;
         st_in[S_DIV+k] = st_ff[S_DIV+k-1];
         dv = {15'b0, st_ff[S_DIV+k-1].len} << SH;
         for (int i = 0; i < 3; i++) begin
            if (st_ff[S_DIV+k-1].drem[i] >= dv) begin
               st_in[S_DIV+k].drem[i]     = st_ff[S_DIV+k-1].drem[i] - dv;
               st_in[S_DIV+k].quot[i][SH] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      logic [15:0] q;
      st_in[S_TAN] = st_ff[S_TAN-1];
      for (int i = 0; i < 3; i++) begin
         q = {1'b0, st_ff[S_TAN-1].quot[i]};
         if (st_ff[S_TAN-1].len == '0) begin
            st_in[S_TAN].tan[i] = '0;
         end else begin
            st_in[S_TAN].tan[i] = st_ff[S_TAN-1].aneg[i] ? (16'd0 - q) : q;
         end
      end
   end

   // cross product terms of normal and tangent
   always_comb begin
      st_in[S_NT] = st_ff[S_NT-1];
      st_in[S_NT].nt[0] = $signed(st_ff[S_NT-1].nrm[1]) * $signed(st_ff[S_NT-1].tan[2]);
      st_in[S_NT].nt[1] = $signed(st_ff[S_NT-1].nrm[2]) * $signed(st_ff[S_NT-1].tan[1]);
      st_in[S_NT].nt[2] = $signed(st_ff[S_NT-1].nrm[2]) * $signed(st_ff[S_NT-1].tan[0]);
      st_in[S_NT].nt[3] = $signed(st_ff[S_NT-1].nrm[0]) * $signed(st_ff[S_NT-1].tan[2]);
      st_in[S_NT].nt[4] = $signed(st_ff[S_NT-1].nrm[0]) * $signed(st_ff[S_NT-1].tan[1]);
      st_in[S_NT].nt[5] = $signed(st_ff[S_NT-1].nrm[1]) * $signed(st_ff[S_NT-1].tan[0]);
   end

   always_comb begin
      logic signed [32:0] diff;
      longint             bv;
      st_in[S_BAX] = st_ff[S_BAX-1];
      for (int i = 0; i < 3; i++) begin
         diff = $signed({st_ff[S_BAX-1].nt[2*i][31], st_ff[S_BAX-1].nt[2*i]}) -
                $signed({st_ff[S_BAX-1].nt[2*i+1][31], st_ff[S_BAX-1].nt[2*i+1]});
         bv   = stf_pkg::rshr14(longint'(diff));
         st_in[S_BAX].bax[i] = bv[17:0];
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/surfel_to_triangle_fan.sv -----
// surfel_to_triangle_fan: turns each surfel into a hexagon triangle fan.
// req channel: one surfel per transaction. rsp channel: seven vertex results
// (centre, then rim vertices) followed by six triangle results; tuser is the
// kind (0 vertex, 1 triangle), tlast marks the final triangle of a surfel.
// csr port: register writes take effect at once and are meant for idle time.
// The tangent pipeline holds 56 stages (32 square root stages and 15 divide
// stages), then come a sequencer stage and the rim pipeline.
// Throughput: one result per cycle while rsp_tready is high, set by the
// sequencer issuing one vertex or triangle slot per cycle into the rim path.
// Up to 56 surfels queue in the tangent pipeline while results drain.
// Reset: clears all valid bits and loads register defaults; no warm-up.
// Stall: when rsp_tvalid is high and rsp_tready low the rim pipeline and
// sequencer hold; req stays ready as long as the tangent pipeline tail is empty.
`default_nettype none
module surfel_to_triangle_fan (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // index, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, radius,
   // color_red, color_green, color_blue
   input  wire  [stf_pkg::REQ_BITS-1:0]         req_tdata,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // vertex_x, vertex_y, vertex_z, vertex_color, vertex_number, tri_first,
   // tri_second, tri_third, radius_bad, zero fill
   output logic [stf_pkg::RSP_BITS-1:0]         rsp_tdata,
   // kind
   output logic                                 rsp_tuser,
   output logic                                 rsp_tlast,
   input  wire                                  csr_we,
   input  wire  [stf_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  wire  [stf_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int RSTAGES = 5;
   localparam int TABN    = 1 << stf_pkg::SLOT_BITS;

   typedef struct packed {
      logic                              kind;
      logic                              last;
      logic                              bad;
      logic [31:0]                       color;
      logic [stf_pkg::VNUM_BITS-1:0]     vnum;
      logic [2:0][stf_pkg::VNUM_BITS-1:0] tri_v;
      logic [2:0][31:0]                  pos;
      logic [15:0]                       cs;
      logic [15:0]                       sn;
      logic [2:0][15:0]                  tan;
      logic [2:0][17:0]                  bax;
      logic [36:0]                       rs;
      logic [2:0][31:0]                  pct;
      logic [2:0][33:0]                  psb;
      logic [2:0][19:0]                  dir;
      logic [2:0][38:0]                  lo;
      logic [2:0][39:0]                  hi;
      logic [2:0][44:0]                  off;
   } rim_type;

   stf_pkg::cfg_type   cfg_ff;
   logic               axis_valid;
   stf_pkg::work_type  axis_item;
   logic               ben;
   logic               seq_load;
   logic               seq_last;
   logic               seq_v_ff;
   logic [stf_pkg::SLOT_BITS-1:0] seq_slot_ff;
   stf_pkg::work_type  seq_ff;
   rim_type            rim_ff [RSTAGES];
   rim_type            rim_in [RSTAGES];
   logic [RSTAGES-1:0] rim_v_ff;
   logic [15:0]        cos_tab [TABN];
   logic [15:0]        sin_tab [TABN];
   logic [stf_pkg::RSP_BITS-1:0] rsp_tdata_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.color_mode    <= stf_pkg::COLOR_MODE_RESET;
         cfg_ff.radius_scale  <= stf_pkg::RADIUS_SCALE_RESET;
         cfg_ff.tan_threshold <= stf_pkg::TAN_THRESH_RESET;
         cfg_ff.min_radius    <= stf_pkg::MIN_RADIUS_RESET;
      end else if (csr_we) begin
         case (stf_pkg::csr_index_type'(csr_index))
            stf_pkg::CSR_COLOR_MODE:    cfg_ff.color_mode    <= csr_wdata[0];
            stf_pkg::CSR_RADIUS_SCALE:  cfg_ff.radius_scale  <= csr_wdata;
            stf_pkg::CSR_TAN_THRESHOLD: cfg_ff.tan_threshold <= csr_wdata[14:0];
            stf_pkg::CSR_MIN_RADIUS:    cfg_ff.min_radius    <= csr_wdata;
            default: ;
         endcase
      end
   end

   stf_axis u_axis (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .cfg       (cfg_ff),
      .out_valid (axis_valid),
      .out_take  (seq_load),
      .out_item  (axis_item)
   );

   // rim angle tables by slot; centre and triangle slots read zero
   for (genvar g = 0; g < TABN; g++) begin : g_tab
      if (g >= 1 && g <= stf_pkg::RIM_VERTICES) begin : g_rim
         assign cos_tab[g] = 16'(stf_pkg::trig_val(g - 1, 1'b1));
         assign sin_tab[g] = 16'(stf_pkg::trig_val(g - 1, 1'b0));
      end else begin : g_zero
         assign cos_tab[g] = '0;
         assign sin_tab[g] = '0;
      end
   end

   assign ben      = !rsp_tvalid || rsp_tready;
   assign seq_last = seq_slot_ff == stf_pkg::SLOT_BITS'(stf_pkg::SLOTS - 1);
   assign seq_load = ben && (!seq_v_ff || seq_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_v_ff    <= 1'b0;
         seq_slot_ff <= '0;
      end else if (seq_load) begin
         seq_v_ff    <= axis_valid;
         seq_slot_ff <= '0;
      end else if (ben && seq_v_ff) begin
         seq_slot_ff <= seq_slot_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_load) seq_ff <= axis_item;
   end

   // slot decode: vertices by slot, then fan triangles
   always_comb begin
      logic [stf_pkg::VNUM_BITS-1:0] tri_off;
      rim_in[0]      = '0;
      rim_in[0].bad  = seq_ff.bad;
      rim_in[0].pos  = seq_ff.pos;
      rim_in[0].tan  = seq_ff.tan;
      rim_in[0].bax  = seq_ff.bax;
      rim_in[0].rs   = seq_ff.rs;
      rim_in[0].cs   = cos_tab[seq_slot_ff];
      rim_in[0].sn   = sin_tab[seq_slot_ff];
      rim_in[0].last = seq_last;
      tri_off = stf_pkg::VNUM_BITS'(seq_slot_ff) -
                stf_pkg::VNUM_BITS'(stf_pkg::RIM_VERTICES);
      if (seq_slot_ff > stf_pkg::SLOT_BITS'(stf_pkg::RIM_VERTICES)) begin
         rim_in[0].kind     = 1'b1;
         rim_in[0].tri_v[0] = seq_ff.base;
         rim_in[0].tri_v[1] = seq_ff.base + tri_off;
         rim_in[0].tri_v[2] = seq_last ? (seq_ff.base + 1'b1) : (seq_ff.base + tri_off + 1'b1);
      end else begin
         rim_in[0].color = seq_ff.color;
         rim_in[0].vnum  = seq_ff.base + stf_pkg::VNUM_BITS'(seq_slot_ff);
      end
   end

   always_comb begin
      rim_in[1] = rim_ff[0];
      for (int i = 0; i < 3; i++) begin
         rim_in[1].pct[i] = $signed(rim_ff[0].cs) * $signed(rim_ff[0].tan[i]);
         rim_in[1].psb[i] = $signed(rim_ff[0].sn) * $signed(rim_ff[0].bax[i]);
      end
   end

   always_comb begin
      longint dv;
      rim_in[2] = rim_ff[1];
      for (int i = 0; i < 3; i++) begin
         dv = stf_pkg::rshr14(longint'($signed(rim_ff[1].pct[i])) +
                              longint'($signed(rim_ff[1].psb[i])));
         rim_in[2].dir[i] = dv[19:0];
      end
   end

   // radius times direction, split into two partial products
   always_comb begin
      rim_in[3] = rim_ff[2];
      for (int i = 0; i < 3; i++) begin
         rim_in[3].lo[i] = $signed({1'b0, rim_ff[2].rs[17:0]}) * $signed(rim_ff[2].dir[i]);
         rim_in[3].hi[i] = $signed({1'b0, rim_ff[2].rs[36:18]}) * $signed(rim_ff[2].dir[i]);
      end
   end

   always_comb begin
      longint ov;
      rim_in[4] = rim_ff[3];
      for (int i = 0; i < 3; i++) begin
         ov = stf_pkg::rshr14((longint'($signed(rim_ff[3].hi[i])) <<< 18) +
                              longint'($signed(rim_ff[3].lo[i])));
         rim_in[4].off[i] = ov[44:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rim_v_ff <= '0;
      end else if (ben) begin
         rim_v_ff <= {rim_v_ff[RSTAGES-2:0], seq_v_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (ben) begin
         for (int k = 0; k < RSTAGES; k++) rim_ff[k] <= rim_in[k];
      end
   end

   // centre plus offset, saturated to 32 bits
   always_comb begin
      logic signed [45:0] sm;
      logic [2:0][31:0]   vx;
      for (int i = 0; i < 3; i++) begin
         sm = $signed({{14{rim_ff[4].pos[i][31]}}, rim_ff[4].pos[i]}) +
              $signed({rim_ff[4].off[i][44], rim_ff[4].off[i]});
         if (sm[45]) begin
            vx[i] = (&sm[44:31]) ? sm[31:0] : 32'h8000_0000;
         end else begin
            vx[i] = (|sm[44:31]) ? 32'h7FFF_FFFF : sm[31:0];
         end
         if (rim_ff[4].kind) vx[i] = '0;
      end
      rsp_tdata_in = {3'b0, rim_ff[4].bad, rim_ff[4].tri_v[2], rim_ff[4].tri_v[1],
                      rim_ff[4].tri_v[0], rim_ff[4].vnum, rim_ff[4].color,
                      vx[2], vx[1], vx[0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid <= 1'b0;
      end else if (ben) begin
         rsp_tvalid <= rim_v_ff[RSTAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (ben) begin
         rsp_tdata <= rsp_tdata_in;
         rsp_tuser <= rim_ff[4].kind;
         rsp_tlast <= rim_ff[4].last;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/stf_checker.sv -----
`default_nettype none
module stf_checker (
   input wire                           clock,
   input wire                           reset,
   input wire                           rsp_tvalid,
   input wire                           rsp_tready,
   input wire [stf_pkg::RSP_BITS-1:0]   rsp_tdata,
   input wire                           rsp_tuser,
   input wire                           rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp transaction changed while stalled");

   a_last_is_tri: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("tlast on a vertex result");

   a_vertex_no_tri: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[235:155] == '0)
      else $error("vertex result carries triangle indices");

   a_tri_no_vertex: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[154:0] == '0)
      else $error("triangle result carries vertex data");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

endmodule

bind surfel_to_triangle_fan stf_checker u_stf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire

// ----- test/stf_checker.sv -----
`timescale 1ns / 100ps
`default_nettype none
module stf_scoreboard (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   input  wire                                req_tready,
   // index, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, radius,
   // color_red, color_green, color_blue
   input  wire  [stf_pkg::REQ_BITS-1:0]       req_tdata,
   input  wire                                rsp_tvalid,
   input  wire                                rsp_tready,
   // vertex_x, vertex_y, vertex_z, vertex_color, vertex_number, tri_first,
   // tri_second, tri_third, radius_bad, zero fill
   input  wire  [stf_pkg::RSP_BITS-1:0]       rsp_tdata,
   // kind
   input  wire                                rsp_tuser,
   input  wire                                rsp_tlast,
   input  wire                                csr_we,
   input  wire  [stf_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire  [stf_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output int                                 errors,
   output int                                 pending,
   output int                                 surfels_seen,
   output int                                 results_seen,
   output int                                 flagged_seen
);

   typedef struct {
      logic                          kind;
      logic [31:0]                   vx;
      logic [31:0]                   vy;
      logic [31:0]                   vz;
      logic [31:0]                   color;
      logic [stf_pkg::VNUM_BITS-1:0] vnum;
      logic [stf_pkg::VNUM_BITS-1:0] tri_a;
      logic [stf_pkg::VNUM_BITS-1:0] tri_b;
      logic [stf_pkg::VNUM_BITS-1:0] tri_c;
      logic                          bad;
      logic                          last;
   } fan_item_type;

   fan_item_type fan_q[$];

   logic        mode_q;
   logic [15:0] scale_q;
   logic [14:0] thresh_q;
   logic [15:0] minrad_q;

   // q28 taylor terms of sin(pi/2 x): x, x^3, x^5, x^7, x^9
   localparam longint unsigned TAYLOR [5] = '{
      64'd421657428, 64'd173399667, 64'd21392327, 64'd1256749, 64'd43068
   };

   function automatic longint unsigned abs_of(longint v);
      return (v < 0) ? (64'd0 - 64'(v)) : 64'(v);
   endfunction

   function automatic longint round_shift(longint v, int s);
      longint unsigned m;
      m = (abs_of(v) + (64'd1 << (s - 1))) >> s;
      return (v < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned r;
      longint unsigned bt;
      r = 0;
      bt = 64'd1 << 62;
      while (bt > v) bt >>= 2;
      while (bt != 0) begin
         if (v >= r + bt) begin
            v -= r + bt;
            r = (r >> 1) + bt;
         end else begin
            r >>= 1;
         end
         bt >>= 2;
      end
      return r;
   endfunction

   function automatic longint sine_quarter(longint unsigned u);
      longint unsigned z;
      longint unsigned acc;
      z = u * u;
      acc = TAYLOR[4];
      for (int k = 3; k >= 0; k--) acc = TAYLOR[k] - ((acc * z) >> 28);
      acc = (acc * u + (64'd1 << 27)) >> 28;
      if (acc > 64'd16384) acc = 64'd16384;
      return longint'(acc);
   endfunction

   task automatic build_fan(input logic [stf_pkg::REQ_BITS-1:0] d);
      longint          p[3];
      longint          n[3];
      longint          a[3];
      longint          t[3];
      longint          b[3];
      longint          dsel;
      longint          cs;
      longint          sn;
      longint          sa;
      longint          sb;
      longint          dir;
      longint          off;
      longint unsigned sum;
      longint unsigned len;
      longint unsigned m;
      longint unsigned rs;
      longint unsigned ang;
      longint unsigned u;
      logic [stf_pkg::VNUM_BITS-1:0] base;
      logic [31:0]     color;
      logic            use_y;
      logic            bad;
      fan_item_type    it;
      p[0] = longint'($signed(d[55:24]));
      p[1] = longint'($signed(d[87:56]));
      p[2] = longint'($signed(d[119:88]));
      n[0] = longint'($signed(d[135:120]));
      n[1] = longint'($signed(d[151:136]));
      n[2] = longint'($signed(d[167:152]));
      use_y = abs_of(n[0]) > 64'(thresh_q);
      dsel = use_y ? n[1] : n[0];
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         a[i] = -dsel * n[i];
         // seed axis is unit y or unit x
         if ((use_y && i == 1) || (!use_y && i == 0)) a[i] += 64'sd1 << 28;
         sum += abs_of(a[i]) * abs_of(a[i]);
         t[i] = 0;
      end
      len = root_floor(sum);
      if (len != 0)
         for (int i = 0; i < 3; i++) begin
            m = (abs_of(a[i]) * 64'd16384 + len / 2) / len;
            t[i] = (a[i] < 0) ? -longint'(m) : longint'(m);
         end
      b[0] = round_shift(n[1] * t[2] - n[2] * t[1], 14);
      b[1] = round_shift(n[2] * t[0] - n[0] * t[2], 14);
      b[2] = round_shift(n[0] * t[1] - n[1] * t[0], 14);
      rs = (64'(d[199:168]) * 64'(scale_q) + 64'd2048) >> 12;
      bad = rs <= 64'(minrad_q);
      color = mode_q ? 32'(d[23:0] + 25'd1) : {8'hFF, d[223:200]};
      base = stf_pkg::VNUM_BITS'(64'(d[23:0]) * 7);
      if (bad) flagged_seen++;
      for (int j = 0; j <= stf_pkg::RIM_VERTICES; j++) begin
         it = '{default: '0};
         it.color = color;
         it.bad = bad;
         it.vnum = base + stf_pkg::VNUM_BITS'(j);
         if (j == 0) begin
            it.vx = p[0][31:0];
            it.vy = p[1][31:0];
            it.vz = p[2][31:0];
         end else begin
            ang = ((64'(j - 1) * 64'd65536 + 64'(stf_pkg::RIM_VERTICES / 2)) /
                   64'(stf_pkg::RIM_VERTICES)) & 64'hFFFF;
            u = ang & 64'h3FFF;
            sa = sine_quarter(u);
            sb = sine_quarter(64'd16384 - u);
            case (ang >> 14)
               64'd0: begin sn = sa;  cs = sb;  end
               64'd1: begin sn = sb;  cs = -sa; end
               64'd2: begin sn = -sa; cs = -sb; end
               default: begin sn = -sb; cs = sa; end
            endcase
            for (int i = 0; i < 3; i++) begin
               dir = round_shift(cs * t[i] + sn * b[i], 14);
               off = round_shift(longint'(rs) * dir, 14);
               off = clamp32(p[i] + off);
               if (i == 0) it.vx = off[31:0];
               else if (i == 1) it.vy = off[31:0];
               else it.vz = off[31:0];
            end
         end
         fan_q.push_back(it);
      end
      for (int l = 0; l < stf_pkg::RIM_VERTICES; l++) begin
         it = '{default: '0};
         it.kind = 1'b1;
         it.bad = bad;
         it.tri_a = base;
         it.tri_b = base + stf_pkg::VNUM_BITS'(1 + l);
         it.tri_c = base + stf_pkg::VNUM_BITS'(1 + (l + 1) % stf_pkg::RIM_VERTICES);
         it.last = (l == stf_pkg::RIM_VERTICES - 1);
         fan_q.push_back(it);
      end
   endtask

   task automatic report(input string what, input longint unsigned got,
                         input longint unsigned want);
      $display("mismatch at %0t on result %0d: %s got 0x%0h want 0x%0h",
               $realtime, results_seen, what, got, want);
      errors++;
   endtask

   task automatic check_result();
      fan_item_type w;
      if (fan_q.size() == 0) begin
         report("unexpected result", 64'(rsp_tuser), 64'd0);
         return;
      end
      w = fan_q.pop_front();
      if (rsp_tuser !== w.kind) report("kind", 64'(rsp_tuser), 64'(w.kind));
      if (rsp_tdata[31:0] !== w.vx)
         report("vertex_x", 64'(rsp_tdata[31:0]), 64'(w.vx));
      if (rsp_tdata[63:32] !== w.vy)
         report("vertex_y", 64'(rsp_tdata[63:32]), 64'(w.vy));
      if (rsp_tdata[95:64] !== w.vz)
         report("vertex_z", 64'(rsp_tdata[95:64]), 64'(w.vz));
      if (rsp_tdata[127:96] !== w.color)
         report("vertex_color", 64'(rsp_tdata[127:96]), 64'(w.color));
      if (rsp_tdata[154:128] !== w.vnum)
         report("vertex_number", 64'(rsp_tdata[154:128]), 64'(w.vnum));
      if (rsp_tdata[181:155] !== w.tri_a)
         report("tri_first", 64'(rsp_tdata[181:155]), 64'(w.tri_a));
      if (rsp_tdata[208:182] !== w.tri_b)
         report("tri_second", 64'(rsp_tdata[208:182]), 64'(w.tri_b));
      if (rsp_tdata[235:209] !== w.tri_c)
         report("tri_third", 64'(rsp_tdata[235:209]), 64'(w.tri_c));
      if (rsp_tdata[236] !== w.bad)
         report("radius_bad", 64'(rsp_tdata[236]), 64'(w.bad));
      if (rsp_tlast !== w.last) report("last", 64'(rsp_tlast), 64'(w.last));
   endtask

   initial begin
      errors = 0;
      pending = 0;
      surfels_seen = 0;
      results_seen = 0;
      flagged_seen = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         mode_q   <= stf_pkg::COLOR_MODE_RESET;
         scale_q  <= stf_pkg::RADIUS_SCALE_RESET;
         thresh_q <= stf_pkg::TAN_THRESH_RESET;
         minrad_q <= stf_pkg::MIN_RADIUS_RESET;
      end else begin
         if (csr_we)
            case (stf_pkg::csr_index_type'(csr_index))
               stf_pkg::CSR_COLOR_MODE:    mode_q   <= csr_wdata[0];
               stf_pkg::CSR_RADIUS_SCALE:  scale_q  <= csr_wdata;
               stf_pkg::CSR_TAN_THRESHOLD: thresh_q <= csr_wdata[14:0];
               stf_pkg::CSR_MIN_RADIUS:    minrad_q <= csr_wdata;
               default: ;
            endcase
         if (rsp_tvalid && rsp_tready) begin
            check_result();
            results_seen++;
         end
         if (req_tvalid && req_tready) begin
            build_fan(req_tdata);
            surfels_seen++;
         end
         pending = fan_q.size();
      end
   end

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

   localparam int CYCLE_LIMIT = 400000;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [stf_pkg::REQ_BITS-1:0]      req_tdata = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [stf_pkg::RSP_BITS-1:0]      rsp_tdata;
   logic                              rsp_tuser;
   logic                              rsp_tlast;
   logic                              csr_we = 1'b0;
   logic [stf_pkg::CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [stf_pkg::CSR_DATA_BITS-1:0] csr_wdata = '0;

   int errors;
   int pending;
   int surfels_seen;
   int results_seen;
   int flagged_seen;
   int cycles = 0;
   int stall_left = 0;
   int settings_used = 0;
   bit bursty = 1'b1;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   surfel_to_triangle_fan dut (.*);

   stf_scoreboard checker_i (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
         $display("tb_top: errors");
         $finish;
      end
   end

   // result side backpressure in random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (bursty && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 10);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [stf_pkg::REQ_BITS-1:0] pack_surfel(
      logic [23:0] idx, logic [31:0] px, logic [31:0] py, logic [31:0] pz,
      logic [15:0] nx, logic [15:0] ny, logic [15:0] nz, logic [31:0] rad,
      logic [23:0] bgr);
      return {bgr, rad, nz, ny, nx, pz, py, px, idx};
   endfunction

   task automatic send_surfel(input logic [stf_pkg::REQ_BITS-1:0] d);
      if (bursty && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
   endtask

   // stop sending and wait for every outstanding result
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input stf_pkg::csr_index_type idx, input logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_setting(input logic mode, input logic [15:0] scale,
                               input logic [14:0] thresh, input logic [15:0] minr);
      write_reg(stf_pkg::CSR_COLOR_MODE, {15'd0, mode});
      write_reg(stf_pkg::CSR_RADIUS_SCALE, scale);
      write_reg(stf_pkg::CSR_TAN_THRESHOLD, {1'b0, thresh});
      write_reg(stf_pkg::CSR_MIN_RADIUS, minr);
      settings_used++;
   endtask

   function automatic logic [15:0] pick_normal();
      case ($urandom_range(0, 9))
         0: return 16'($urandom);
         1: return 16'sd16384;
         2: return -16'sd16384;
         3: return 16'($urandom_range(0, 400)) - 16'd200;
         default: return 16'($urandom_range(0, 32768)) - 16'd16384;
      endcase
   endfunction

   function automatic logic [stf_pkg::REQ_BITS-1:0] random_surfel();
      logic [31:0] pos[3];
      logic [31:0] rad;
      for (int i = 0; i < 3; i++)
         pos[i] = ($urandom_range(0, 3) == 0) ? $urandom
                  : 32'($urandom_range(0, 32'h00FFFFFF)) - 32'h007FFFFF;
      case ($urandom_range(0, 3))
         0: rad = $urandom;
         1: rad = $urandom_range(0, 60000);
         default: rad = $urandom_range(0, 32'h0004FFFF);
      endcase
      return pack_surfel(24'($urandom), pos[0], pos[1], pos[2], pick_normal(),
                         pick_normal(), pick_normal(), rad, 24'($urandom));
   endfunction

   task automatic directed_block();
      logic [31:0] big;
      logic [31:0] low;
      logic [31:0] z32;
      logic [15:0] z16;
      logic [15:0] one;
      logic [15:0] mone;
      big  = 32'h7FFFFFFF;
      low  = 32'h80000000;
      z32  = 32'd0;
      z16  = 16'd0;
      one  = 16'd16384;
      mone = 16'(-16384);
      // normal along each axis, both signs
      send_surfel(pack_surfel(24'd0, z32, z32, z32, one, z16, z16, 32'h10000, 24'h000000));
      send_surfel(pack_surfel(24'd1, z32, z32, z32, mone, z16, z16, 32'h10000, 24'hFFFFFF));
      send_surfel(pack_surfel(24'd2, z32, z32, z32, z16, one, z16, 32'h10000, 24'h123456));
      send_surfel(pack_surfel(24'd3, z32, z32, z32, z16, mone, z16, 32'h10000, 24'hABCDEF));
      send_surfel(pack_surfel(24'd4, z32, z32, z32, z16, z16, one, 32'h10000, 24'h0F0F0F));
      send_surfel(pack_surfel(24'd5, z32, z32, z32, z16, z16, mone, 32'h10000, 24'hF0F0F0));
      // zero and out-of-range normal codes
      send_surfel(pack_surfel(24'd6, 32'h10000, z32, z32, z16, z16, z16, 32'h10000,
                              24'h0));
      send_surfel(pack_surfel(24'd7, z32, z32, z32, 16'h8000, 16'h7FFF, 16'h8000,
                              32'h20000, 24'h0));
      // radius extremes and saturation at the position limits
      send_surfel(pack_surfel(24'd8, big, big, big, 16'd9459, 16'd9459, 16'd9459,
                              32'hFFFFFFFF, 24'h808080));
      send_surfel(pack_surfel(24'd9, low, low, low, 16'(-9459), 16'(-9459), 16'(-9459),
                              32'hFFFFFFFF, 24'h7F7F7F));
      send_surfel(pack_surfel(24'hFFFFFF, big, low, z32, 16'd11585, z16, 16'd11585,
                              32'd0, 24'hFFFFFF));
      send_surfel(pack_surfel(24'hFFFFFE, z32, z32, z32, 16'd14746, 16'd8000, z16,
                              32'd1, 24'h0));
      send_surfel(pack_surfel(24'd12, z32, z32, z32, 16'd14747, 16'd7000, z16, 32'd2,
                              24'h0));
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_block();
      drain();

      load_setting(1'b1, 16'hFFFF, 15'd16384, 16'hFFFF);
      directed_block();
      drain();

      load_setting(1'b0, 16'h0000, 15'd0, 16'h0000);
      for (int k = 0; k < 40; k++) send_surfel(random_surfel());
      drain();

      load_setting(1'b1, 16'd4096, 15'd8192, 16'd100);
      for (int k = 0; k < 70; k++) send_surfel(random_surfel());
      drain();

      load_setting(1'($urandom), 16'($urandom), 15'($urandom_range(0, 16384)),
                   16'($urandom));
      for (int k = 0; k < 70; k++) send_surfel(random_surfel());
      drain();

      // closing stretch at full rate on both sides
      load_setting(1'b0, 16'd6144, 15'd14746, 16'd1);
      bursty = 1'b0;
      for (int k = 0; k < 45; k++) send_surfel(random_surfel());
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);

      $display("covered %0d surfels and %0d results over %0d register settings",
               surfels_seen, results_seen, settings_used + 1);
      $display("%0d surfels flagged for small radius", flagged_seen);
      if (errors == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
`default_nettype wire
